// ----- design/scg_pkg.sv -----
// Shared types and constants for the sphere contact generator.
`default_nettype none

package scg_pkg;

  localparam int unsigned MAX_CONTACTS = 1024;
  localparam int unsigned CAP_W        = 11;
  localparam int unsigned EPS_W        = 17;
  localparam int unsigned SLOT_W       = 10;
  localparam int unsigned Q_ONE        = 65536;

  typedef enum logic [1:0] {
    ACT_SPHERE = 2'd0,
    ACT_PLANE  = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_EPSILON  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MS_SQ  = 3'd0,
    MS_RSQ = 3'd1,
    MS_DOT = 3'd2,
    MS_NSQ = 3'd3,
    MS_POS = 3'd4
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic [1:0] idx;
    logic     sqrt_start;
    logic     check;
    logic     prep;
    logic     div_start;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic    mul_done;
    logic    sqrt_done;
    logic    div_done;
    logic    hit;
    logic    coin;
    logic    out_free;
    action_t action;
  } status_t;

endpackage

`default_nettype wire

// ----- design/scg_ctrl.sv -----
// Controller state machine that sequences the contact datapath.
`default_nettype none

module scg_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  scg_pkg::status_t status,
  output scg_pkg::cmd_t   cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_MUL    = 8'b0000_0100,
    S_CHECK  = 8'b0000_1000,
    S_SQRT   = 8'b0001_0000,
    S_PREP   = 8'b0010_0000,
    S_DIV    = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  scg_pkg::mul_sel_t sel_r, sel_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic              started_r, started_nxt;

  always_comb begin
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    idx_nxt     = idx_r;
    started_nxt = started_r;
    cmd         = '0;
    cmd.mul_sel = sel_r;
    cmd.idx     = idx_r;
    in_ready    = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        idx_nxt = 2'd0;
        case (status.action)
          scg_pkg::ACT_SPHERE: begin
            sel_nxt   = scg_pkg::MS_SQ;
            state_nxt = S_MUL;
          end
          scg_pkg::ACT_PLANE: begin
            sel_nxt   = scg_pkg::MS_DOT;
            state_nxt = S_MUL;
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_MUL: begin
        if (!started_r) begin
          cmd.mul_start = 1'b1;
          started_nxt   = 1'b1;
        end else if (status.mul_done) begin
          started_nxt = 1'b0;
          case (sel_r)
            scg_pkg::MS_SQ: begin
              if (idx_r == 2'd2) begin
                sel_nxt = scg_pkg::MS_RSQ;
                idx_nxt = 2'd0;
              end else begin
                idx_nxt = idx_r + 2'd1;
              end
            end
            scg_pkg::MS_RSQ: state_nxt = S_CHECK;
            scg_pkg::MS_DOT: begin
              if (idx_r == 2'd2) state_nxt = S_CHECK;
              else idx_nxt = idx_r + 2'd1;
            end
            scg_pkg::MS_NSQ: begin
              if (idx_r == 2'd2) state_nxt = S_SQRT;
              else idx_nxt = idx_r + 2'd1;
            end
            scg_pkg::MS_POS: begin
              if (idx_r == 2'd2) begin
                state_nxt = S_FINISH;
              end else begin
                idx_nxt   = idx_r + 2'd1;
                state_nxt = S_DIV;
              end
            end
            default: state_nxt = S_FINISH;
          endcase
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (!status.hit) begin
          state_nxt = S_FINISH;
        end else if (status.action == scg_pkg::ACT_SPHERE) begin
          state_nxt = S_SQRT;
        end else begin
          sel_nxt   = scg_pkg::MS_NSQ;
          idx_nxt   = 2'd0;
          state_nxt = S_MUL;
        end
      end
      S_SQRT: begin
        if (!started_r) begin
          cmd.sqrt_start = 1'b1;
          started_nxt    = 1'b1;
        end else if (status.sqrt_done) begin
          started_nxt = 1'b0;
          state_nxt   = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        idx_nxt  = 2'd0;
        if (status.coin) state_nxt = S_FINISH;
        else state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!started_r) begin
          cmd.div_start = 1'b1;
          started_nxt   = 1'b1;
        end else if (status.div_done) begin
          started_nxt = 1'b0;
          sel_nxt     = scg_pkg::MS_POS;
          state_nxt   = S_MUL;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      sel_r     <= scg_pkg::MS_SQ;
      idx_r     <= 2'd0;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sel_r     <= sel_nxt;
      idx_r     <= idx_nxt;
      started_r <= started_nxt;
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state not one-hot");

  a_load_decode: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_DECODE))
    else $error("accepted beat not decoded");

  a_started_unit: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> (state_r == S_MUL || state_r == S_SQRT || state_r == S_DIV))
    else $error("unit start flag outside a unit state");

endmodule

`default_nettype wire

// ----- design/scg_datapath.sv -----
// Datapath: operand registers, shared multiplier, square root, divider, result.
`default_nettype none

module scg_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  scg_pkg::cmd_t        cmd,
  output scg_pkg::status_t     status,
  input  logic [1:0]           in_action,
  input  logic signed [31:0]   in_pos_a_x,
  input  logic signed [31:0]   in_pos_a_y,
  input  logic signed [31:0]   in_pos_a_z,
  input  logic signed [31:0]   in_pos_b_x,
  input  logic signed [31:0]   in_pos_b_y,
  input  logic signed [31:0]   in_pos_b_z,
  input  logic signed [31:0]   in_normal_x,
  input  logic signed [31:0]   in_normal_y,
  input  logic signed [31:0]   in_normal_z,
  input  logic [30:0]          in_radius_a,
  input  logic [30:0]          in_radius_b,
  input  logic                 cfg_valid,
  input  logic [0:0]           cfg_index,
  input  logic [16:0]          cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_contact_made,
  output logic                 out_no_room,
  output logic [9:0]           out_contact_slot,
  output logic [30:0]          out_depth,
  output logic signed [31:0]   out_dir_x,
  output logic signed [31:0]   out_dir_y,
  output logic signed [31:0]   out_dir_z,
  output logic signed [31:0]   out_contact_x,
  output logic signed [31:0]   out_contact_y,
  output logic signed [31:0]   out_contact_z
);

  // item registers
  scg_pkg::action_t    action_r;
  logic signed [31:0]  a_r [3];
  logic signed [31:0]  b_r [3];
  logic signed [31:0]  n_r [3];
  logic signed [32:0]  s_r [3];
  logic [30:0]         ra_r, rb_r;

  // configuration and count
  logic [scg_pkg::CAP_W-1:0] cap_r;
  logic [scg_pkg::EPS_W-1:0] eps_r;
  logic [scg_pkg::CAP_W-1:0] count_r;

  // intermediate results
  logic [66:0]         sqsum_r;
  logic [65:0]         rsq_r;
  logic signed [50:0]  dot_r;
  logic [50:0]         dfull_r;
  logic signed [51:0]  scale_r;
  logic signed [49:0]  dir_r [3];
  logic signed [31:0]  pos_r [3];
  logic                hit_r;

  // multiplier
  logic signed [51:0]  opx_r, opy_r;
  scg_pkg::mul_sel_t   msel_r;
  logic [1:0]          midx_r;
  logic                mul_busy_r, mul_done_r, pv_r;
  logic [2:0]          mcnt_r;
  logic signed [53:0]  pp_r;
  logic [1:0]          psh_r;
  logic [79:0]         acc_r;

  // square root
  logic [63:0]         rad_r;
  logic [32:0]         srem_r;
  logic [31:0]         root_r;
  logic [4:0]          scnt_r;
  logic                sqrt_busy_r, sqrt_done_r;

  // divider
  logic [48:0]         dq_r;
  logic [31:0]         drem_r;
  logic [5:0]          dcnt_r;
  logic                div_busy_r, div_done_r, dneg_r;
  logic [1:0]          didx_r;

  // output
  logic                out_valid_r, made_r, noroom_r;
  logic [9:0]          slot_r;
  logic [30:0]         depth_r;
  logic signed [31:0]  odir_r [3];
  logic signed [31:0]  opos_r [3];

  logic [32:0]         rsum_c;
  logic                is_sphere_c, coin_c, hit_c, out_free_c;
  logic [scg_pkg::CAP_W-1:0] effcap_c;

  assign rsum_c      = {2'b00, ra_r} + {2'b00, rb_r};
  assign is_sphere_c = (action_r == scg_pkg::ACT_SPHERE);
  assign coin_c      = is_sphere_c &&
                       ((root_r < {15'd0, eps_r}) || (root_r == 32'd0));
  assign hit_c       = is_sphere_c ? (sqsum_r < {1'b0, rsq_r})
                                   : (dot_r < $signed({20'd0, rb_r}));
  assign out_free_c  = !out_valid_r || out_ready;
  assign effcap_c    = (cap_r < scg_pkg::CAP_W'(scg_pkg::MAX_CONTACTS)) ?
                       cap_r : scg_pkg::CAP_W'(scg_pkg::MAX_CONTACTS);

  always_comb begin
    status.mul_done  = mul_done_r;
    status.sqrt_done = sqrt_done_r;
    status.div_done  = div_done_r;
    status.hit       = hit_c;
    status.coin      = coin_c;
    status.out_free  = out_free_c;
    status.action    = action_r;
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= scg_pkg::CAP_W'(1024);
      eps_r <= scg_pkg::EPS_W'(1);
    end else if (cfg_valid) begin
      unique case (scg_pkg::cfg_reg_t'(cfg_index))
        scg_pkg::REG_CAPACITY: cap_r <= cfg_data[scg_pkg::CAP_W-1:0];
        scg_pkg::REG_EPSILON:  eps_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- item load ----------------
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= scg_pkg::action_t'(in_action);
      a_r[0] <= in_pos_a_x;  a_r[1] <= in_pos_a_y;  a_r[2] <= in_pos_a_z;
      b_r[0] <= in_pos_b_x;  b_r[1] <= in_pos_b_y;  b_r[2] <= in_pos_b_z;
      n_r[0] <= in_normal_x; n_r[1] <= in_normal_y; n_r[2] <= in_normal_z;
      s_r[0] <= {in_pos_b_x[31], in_pos_b_x} - {in_pos_a_x[31], in_pos_a_x};
      s_r[1] <= {in_pos_b_y[31], in_pos_b_y} - {in_pos_a_y[31], in_pos_a_y};
      s_r[2] <= {in_pos_b_z[31], in_pos_b_z} - {in_pos_a_z[31], in_pos_a_z};
      ra_r <= in_radius_a;
      rb_r <= in_radius_b;
    end
  end

  // ---------------- shared multiplier ----------------
  logic signed [51:0] opx_c, opy_c;
  logic signed [26:0] mx_c, my_c;
  logic signed [53:0] pp_c;
  logic [1:0]         psh_c;
  logic [79:0]        ppx_c, ppsh_c;

  always_comb begin
    opx_c = '0;
    opy_c = '0;
    case (cmd.mul_sel)
      scg_pkg::MS_SQ: begin
        opx_c = {{19{s_r[cmd.idx][32]}}, s_r[cmd.idx]};
        opy_c = opx_c;
      end
      scg_pkg::MS_RSQ: begin
        opx_c = $signed({19'd0, rsum_c});
        opy_c = opx_c;
      end
      scg_pkg::MS_DOT: begin
        opx_c = {{20{n_r[cmd.idx][31]}}, n_r[cmd.idx]};
        opy_c = {{19{s_r[cmd.idx][32]}}, s_r[cmd.idx]};
      end
      scg_pkg::MS_NSQ: begin
        opx_c = {{20{n_r[cmd.idx][31]}}, n_r[cmd.idx]};
        opy_c = opx_c;
      end
      scg_pkg::MS_POS: begin
        opx_c = {{2{dir_r[cmd.idx][49]}}, dir_r[cmd.idx]};
        opy_c = scale_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (mcnt_r[1:0])
      2'd0: begin
        mx_c = $signed({1'b0, opx_r[25:0]});
        my_c = $signed({1'b0, opy_r[25:0]});
        psh_c = 2'd0;
      end
      2'd1: begin
        mx_c = $signed({opx_r[51], opx_r[51:26]});
        my_c = $signed({1'b0, opy_r[25:0]});
        psh_c = 2'd1;
      end
      2'd2: begin
        mx_c = $signed({1'b0, opx_r[25:0]});
        my_c = $signed({opy_r[51], opy_r[51:26]});
        psh_c = 2'd1;
      end
      default: begin
        mx_c = $signed({opx_r[51], opx_r[51:26]});
        my_c = $signed({opy_r[51], opy_r[51:26]});
        psh_c = 2'd2;
      end
    endcase
    pp_c  = mx_c * my_c;
    ppx_c = {{26{pp_r[53]}}, pp_r};
    case (psh_r)
      2'd0:    ppsh_c = ppx_c;
      2'd1:    ppsh_c = ppx_c << 26;
      default: ppsh_c = ppx_c << 52;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      mul_done_r <= 1'b0;
      pv_r       <= 1'b0;
    end else begin
      mul_done_r <= mul_busy_r && (mcnt_r == 3'd4);
      if (cmd.mul_start) begin
        mul_busy_r <= 1'b1;
        pv_r       <= 1'b0;
      end else if (mul_busy_r) begin
        pv_r <= (mcnt_r != 3'd4);
        if (mcnt_r == 3'd4) mul_busy_r <= 1'b0;
      end else begin
        pv_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      opx_r  <= opx_c;
      opy_r  <= opy_c;
      msel_r <= cmd.mul_sel;
      midx_r <= cmd.idx;
      mcnt_r <= 3'd0;
      acc_r  <= '0;
    end else begin
      if (mul_busy_r) begin
        mcnt_r <= mcnt_r + 3'd1;
        pp_r   <= pp_c;
        psh_r  <= psh_c;
      end
      if (pv_r) acc_r <= acc_r + ppsh_c;
    end
  end

  // ---------------- square root, one result bit per cycle ----------------
  logic [34:0] st_c, strial_c;
  logic        sge_c;

  assign st_c     = {srem_r, rad_r[63:62]};
  assign strial_c = {1'b0, root_r, 2'b01};
  assign sge_c    = (st_c >= strial_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqrt_busy_r <= 1'b0;
      sqrt_done_r <= 1'b0;
    end else begin
      sqrt_done_r <= sqrt_busy_r && (scnt_r == 5'd31);
      if (cmd.sqrt_start) sqrt_busy_r <= 1'b1;
      else if (sqrt_busy_r && scnt_r == 5'd31) sqrt_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      rad_r  <= sqsum_r[63:0];
      srem_r <= '0;
      root_r <= '0;
      scnt_r <= '0;
    end else if (sqrt_busy_r) begin
      srem_r <= sge_c ? 33'(st_c - strial_c) : st_c[32:0];
      root_r <= {root_r[30:0], sge_c};
      rad_r  <= {rad_r[61:0], 2'b00};
      scnt_r <= scnt_r + 5'd1;
    end
  end

  // ---------------- divider, one quotient bit per cycle ----------------
  logic signed [32:0] num_c;
  logic [32:0]        mag_c, dt_c;
  logic               dge_c;

  assign num_c = is_sphere_c ? s_r[cmd.idx] : {n_r[cmd.idx][31], n_r[cmd.idx]};
  assign mag_c = num_c[32] ? (~num_c + 33'd1) : num_c;
  assign dt_c  = {drem_r, dq_r[48]};
  assign dge_c = (dt_c >= {1'b0, root_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_done_r <= 1'b0;
    end else begin
      div_done_r <= div_busy_r && (dcnt_r == 6'd48);
      if (cmd.div_start) div_busy_r <= 1'b1;
      else if (div_busy_r && dcnt_r == 6'd48) div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq_r   <= {mag_c, 16'd0};
      drem_r <= '0;
      dcnt_r <= '0;
      dneg_r <= num_c[32];
      didx_r <= cmd.idx;
    end else if (div_busy_r) begin
      drem_r <= dge_c ? 32'(dt_c - {1'b0, root_r}) : dt_c[31:0];
      dq_r   <= {dq_r[47:0], dge_c};
      dcnt_r <= dcnt_r + 6'd1;
    end
  end

  // ---------------- depth, scale and per-axis results ----------------
  logic [50:0]        dfull_c;
  logic signed [51:0] scale_c;
  logic signed [51:0] pd_c;
  logic signed [31:0] base_c;
  logic signed [63:0] psum_c;
  logic signed [31:0] psat_c;

  always_comb begin
    pd_c = $signed({21'd0, rb_r}) - $signed({dot_r[50], dot_r});
    if (is_sphere_c) begin
      dfull_c = {18'd0, rsum_c - {1'b0, root_r}};
      scale_c = $signed({21'd0, ra_r}) - $signed({2'b00, dfull_c[50:1]});
    end else begin
      dfull_c = pd_c[50:0];
      scale_c = $signed({2'b00, dfull_c[50:1]}) - $signed({21'd0, rb_r});
    end
    base_c = is_sphere_c ? a_r[midx_r] : b_r[midx_r];
    psum_c = $signed({{32{base_c[31]}}, base_c}) + $signed(acc_r[79:16]);
    if (psum_c > 64'sd2147483647)       psat_c = 32'sh7FFF_FFFF;
    else if (psum_c < -64'sd2147483648) psat_c = 32'sh8000_0000;
    else                                psat_c = psum_c[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sqsum_r <= '0;
      dot_r   <= '0;
    end else if (mul_done_r) begin
      case (msel_r)
        scg_pkg::MS_SQ:  sqsum_r <= sqsum_r + acc_r[66:0];
        scg_pkg::MS_RSQ: rsq_r   <= acc_r[65:0];
        scg_pkg::MS_DOT: dot_r   <= dot_r + 51'($signed(acc_r[63:16]));
        scg_pkg::MS_NSQ: sqsum_r <= sqsum_r + acc_r[66:0];
        scg_pkg::MS_POS: pos_r[midx_r] <= psat_c;
        default: ;
      endcase
    end
    if (cmd.prep) begin
      dfull_r <= dfull_c;
      scale_r <= scale_c;
      if (coin_c) begin
        dir_r[0] <= 50'(scg_pkg::Q_ONE);
        dir_r[1] <= '0;
        dir_r[2] <= '0;
        pos_r[0] <= a_r[0];
        pos_r[1] <= a_r[1];
        pos_r[2] <= a_r[2];
      end
    end
    if (div_done_r) begin
      if (root_r == 32'd0) dir_r[didx_r] <= '0;
      else if (dneg_r)     dir_r[didx_r] <= -$signed({1'b0, dq_r});
      else                 dir_r[didx_r] <= $signed({1'b0, dq_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) hit_r <= 1'b0;
    else if (cmd.load) hit_r <= 1'b0;
    else if (cmd.check) hit_r <= hit_c;
  end

  // ---------------- result beat and slot count ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
      if (action_r == scg_pkg::ACT_CLEAR) count_r <= '0;
      else if (hit_r && count_r < effcap_c) count_r <= count_r + 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      made_r   <= 1'b0;
      noroom_r <= 1'b0;
      slot_r   <= '0;
      depth_r  <= '0;
      for (int i = 0; i < 3; i++) begin
        odir_r[i] <= '0;
        opos_r[i] <= '0;
      end
      if (hit_r) begin
        if (count_r >= effcap_c) begin
          noroom_r <= 1'b1;
        end else begin
          made_r  <= 1'b1;
          slot_r  <= count_r[scg_pkg::SLOT_W-1:0];
          depth_r <= (dfull_r > 51'h7FFF_FFFF) ? 31'h7FFF_FFFF : dfull_r[30:0];
          for (int i = 0; i < 3; i++) begin
            odir_r[i] <= dir_r[i][31:0];
            opos_r[i] <= pos_r[i];
          end
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_contact_made = made_r;
  assign out_no_room      = noroom_r;
  assign out_contact_slot = slot_r;
  assign out_depth        = depth_r;
  assign out_dir_x        = odir_r[0];
  assign out_dir_y        = odir_r[1];
  assign out_dir_z        = odir_r[2];
  assign out_contact_x    = opos_r[0];
  assign out_contact_y    = opos_r[1];
  assign out_contact_z    = opos_r[2];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= scg_pkg::CAP_W'(scg_pkg::MAX_CONTACTS))
    else $error("contact count beyond buffer size");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result written over a pending beat");

  a_made_xor_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(made_r && noroom_r))
    else $error("contact and no-room flagged together");

  a_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul_start || cmd.sqrt_start || cmd.div_start) |->
      (!mul_busy_r && !sqrt_busy_r && !div_busy_r))
    else $error("unit started while another runs");

endmodule

`default_nettype wire

// ----- design/sphere_contact_generator_top.sv -----
// Top level of the sphere and plane contact generator.
//
//  channel | handshake           | beat contents
//  --------+---------------------+-------------------------------------------
//  in      | in_valid/in_ready   | action, centres, plane normal, radii
//  out     | out_valid/out_ready | contact flag, no-room flag, slot, depth,
//          |                     | direction, contact position
//  cfg     | cfg_valid/cfg_ready | register index, write data
//
// One item at a time; its run time depends on the action and on the outcome (clear or unused action,
// plane miss, sphere miss, coincident centres, overlapping spheres, overlapping plane).
// It is set by the shared multiplier (4 passes per product), the 32-step square root
// and the 49-step divider run once per axis.
// rst_n is synchronous; it clears the count and restores the register defaults.
// A finished beat waits in the output register; the next item is taken meanwhile and
// holds in its last cycle until that beat is accepted.
`default_nettype none

module sphere_contact_generator_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_action,
  input  logic signed [31:0]  in_pos_a_x,
  input  logic signed [31:0]  in_pos_a_y,
  input  logic signed [31:0]  in_pos_a_z,
  input  logic signed [31:0]  in_pos_b_x,
  input  logic signed [31:0]  in_pos_b_y,
  input  logic signed [31:0]  in_pos_b_z,
  input  logic signed [31:0]  in_normal_x,
  input  logic signed [31:0]  in_normal_y,
  input  logic signed [31:0]  in_normal_z,
  input  logic [30:0]         in_radius_a,
  input  logic [30:0]         in_radius_b,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_contact_made,
  output logic                out_no_room,
  output logic [9:0]          out_contact_slot,
  output logic [30:0]         out_depth,
  output logic signed [31:0]  out_dir_x,
  output logic signed [31:0]  out_dir_y,
  output logic signed [31:0]  out_dir_z,
  output logic signed [31:0]  out_contact_x,
  output logic signed [31:0]  out_contact_y,
  output logic signed [31:0]  out_contact_z,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [16:0]         cfg_data
);

  scg_pkg::cmd_t    cmd;
  scg_pkg::status_t status;

  assign cfg_ready = 1'b1;

  scg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  scg_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_action        (in_action),
    .in_pos_a_x       (in_pos_a_x),
    .in_pos_a_y       (in_pos_a_y),
    .in_pos_a_z       (in_pos_a_z),
    .in_pos_b_x       (in_pos_b_x),
    .in_pos_b_y       (in_pos_b_y),
    .in_pos_b_z       (in_pos_b_z),
    .in_normal_x      (in_normal_x),
    .in_normal_y      (in_normal_y),
    .in_normal_z      (in_normal_z),
    .in_radius_a      (in_radius_a),
    .in_radius_b      (in_radius_b),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_contact_made (out_contact_made),
    .out_no_room      (out_no_room),
    .out_contact_slot (out_contact_slot),
    .out_depth        (out_depth),
    .out_dir_x        (out_dir_x),
    .out_dir_y        (out_dir_y),
    .out_dir_z        (out_dir_z),
    .out_contact_x    (out_contact_x),
    .out_contact_y    (out_contact_y),
    .out_contact_z    (out_contact_z)
  );

endmodule

`default_nettype wire
